>>> design/zobrist_position_hash_top_assert.svh
// Assertion macros for the position hash engine. Both expect clk and rst in scope.
`ifndef ZOBRIST_POSITION_HASH_TOP_ASSERT_SVH
`define ZOBRIST_POSITION_HASH_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ZPH_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("zph: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ZPH_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("zph: next-cycle check failed");

`endif

>>> design/zph_pkg.sv
`default_nettype none

package zph_pkg;

  localparam int unsigned PIECE_ROWS_DEF = 13;
  localparam int unsigned SQUARES_DEF    = 120;
  localparam int unsigned CASTLE_KEYS    = 16;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned INDEX_W  = 11;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned SQUARE_W = 7;
  localparam int unsigned PIECE_W  = 4;
  localparam int unsigned CASTLE_W = 4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE_KEY = 2'd0,
    ACT_ADD_PIECE = 2'd1,
    ACT_FINISH    = 2'd2,
    ACT_NONE      = 2'd3
  } action_t;

  typedef logic [KEY_W-1:0] key_t;

endpackage

`default_nettype wire

>>> design/zph_if.sv
`default_nettype none

interface zph_item_if;
  logic                                 valid;
  logic                                 ready;
  logic [zph_pkg::ACTION_W-1:0]         action;
  logic [zph_pkg::INDEX_W-1:0]          key_index;
  logic [zph_pkg::KEY_W-1:0]            key_value;
  logic [zph_pkg::SQUARE_W-1:0]         square;
  logic [zph_pkg::PIECE_W-1:0]          piece;
  logic                                 side_to_move;
  logic                                 enpassant_valid;
  logic [zph_pkg::SQUARE_W-1:0]         enpassant_square;
  logic [zph_pkg::CASTLE_W-1:0]         castle_rights;

  modport source (
    output valid, action, key_index, key_value, square, piece,
           side_to_move, enpassant_valid, enpassant_square, castle_rights,
    input  ready
  );
  modport sink (
    input  valid, action, key_index, key_value, square, piece,
           side_to_move, enpassant_valid, enpassant_square, castle_rights,
    output ready
  );
endinterface

interface zph_hash_if;
  logic                      valid;
  logic                      ready;
  logic [zph_pkg::KEY_W-1:0] hash;

  modport source (output valid, hash, input ready);
  modport sink   (input valid, hash, output ready);
endinterface

`default_nettype wire

>>> design/zobrist_position_hash_top.sv
// Channel    Dir  Beat contents
// item_in    in   action, key_index, key_value, square, piece, side, en passant, castle
// hash_out   out  hash
// cfg        in   empty_piece_code (write enable and data, no handshake)
//
// One item per cycle unless stalled; add and finish beats each do one key memory read.
// A finish beat's hash passes the read stage, then is held in an output register.
// rst clears the running hash, the pipeline valids and the empty code; keys must be loaded.
// A finish waiting in the read stage behind a full output register stalls item_in.

`default_nettype none

module zobrist_position_hash_top #(
  parameter int unsigned PIECE_ROWS = zph_pkg::PIECE_ROWS_DEF,
  parameter int unsigned SQUARES    = zph_pkg::SQUARES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [zph_pkg::PIECE_W-1:0]  cfg_wdata,
  zph_item_if.sink                          item_in,
  zph_hash_if.source                        hash_out
);

  localparam int unsigned PIECE_KEYS  = PIECE_ROWS * SQUARES;
  localparam int unsigned CASTLE_BASE = PIECE_KEYS;
  localparam int unsigned SIDE_INDEX  = CASTLE_BASE + zph_pkg::CASTLE_KEYS;
  localparam int unsigned AW          = $clog2(PIECE_KEYS);

  // Piece and en passant keys live in the memory; castle and side keys sit in
  // registers so that a finish needs only one memory read.
  logic [63:0] key_mem [PIECE_KEYS];
  zph_pkg::key_t castle_keys [zph_pkg::CASTLE_KEYS];
  zph_pkg::key_t side_key;

  logic [zph_pkg::PIECE_W-1:0] empty_code;

  logic          accept;
  logic          is_write;
  logic          is_add;
  logic          is_finish;
  logic [31:0]   index_ext;
  logic          add_hit;
  logic          ep_hit;
  logic [31:0]   rd_row;
  logic [31:0]   rd_sq;
  logic [AW-1:0] rd_addr;
  logic [31:0]   castle_off;

  logic          s1_valid;
  logic          s1_finish;
  logic          s1_hit;
  zph_pkg::key_t s1_extra;
  zph_pkg::key_t rd_data;
  logic          s1_adv;
  zph_pkg::key_t acc;

  zph_pkg::key_t running_hash;
  logic          o_valid;
  zph_pkg::key_t o_hash;

  assign accept    = item_in.valid && item_in.ready;
  assign is_write  = item_in.action == zph_pkg::ACT_WRITE_KEY;
  assign is_add    = item_in.action == zph_pkg::ACT_ADD_PIECE;
  assign is_finish = item_in.action == zph_pkg::ACT_FINISH;
  assign index_ext = 32'(item_in.key_index);
  assign castle_off = index_ext - CASTLE_BASE;

  assign add_hit = (item_in.piece != empty_code) && (32'(item_in.piece) < PIECE_ROWS)
                   && (32'(item_in.square) < SQUARES);
  assign ep_hit  = item_in.enpassant_valid && (32'(item_in.enpassant_square) < SQUARES)
                   && (32'(empty_code) < PIECE_ROWS);

  always_comb begin
    if (is_finish) begin
      rd_row = 32'(empty_code);
      rd_sq  = 32'(item_in.enpassant_square);
    end else begin
      rd_row = 32'(item_in.piece);
      rd_sq  = 32'(item_in.square);
    end
  end

  assign rd_addr = AW'(rd_row * SQUARES + rd_sq);

  assign s1_adv       = s1_valid && (!s1_finish || !o_valid || hash_out.ready);
  assign item_in.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      empty_code <= '0;
    end else if (cfg_we) begin
      empty_code <= cfg_wdata;
    end
  end

  // Key memory: written by load beats, read by add and finish beats.
  always_ff @(posedge clk) begin
    if (accept && is_write && (index_ext < PIECE_KEYS)) begin
      key_mem[item_in.key_index[AW-1:0]] <= item_in.key_value;
    end
    if (accept && (is_add || is_finish)) begin
      rd_data <= key_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_write && (index_ext >= CASTLE_BASE) && (index_ext < SIDE_INDEX)) begin
      castle_keys[castle_off[zph_pkg::CASTLE_W-1:0]] <= item_in.key_value;
    end
    if (accept && is_write && (index_ext == SIDE_INDEX)) begin
      side_key <= item_in.key_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_in.ready) begin
      s1_valid <= accept && (is_add || is_finish);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_finish <= is_finish;
      s1_hit    <= is_finish ? ep_hit : add_hit;
      s1_extra  <= (item_in.side_to_move ? side_key : '0)
                   ^ castle_keys[item_in.castle_rights];
    end
  end

  assign acc = running_hash ^ (s1_hit ? rd_data : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
    end else if (s1_adv) begin
      running_hash <= s1_finish ? '0 : acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_adv && s1_finish) begin
      o_valid <= 1'b1;
    end else if (hash_out.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_finish) begin
      o_hash <= acc ^ s1_extra;
    end
  end

  assign hash_out.valid = o_valid;
  assign hash_out.hash  = o_hash;

`include "zobrist_position_hash_top_assert.svh"

  `ZPH_ASSERT_NOW(a_finish_blocks_input,
                  s1_valid && s1_finish && o_valid && !hash_out.ready, !item_in.ready)
  `ZPH_ASSERT_NEXT(a_finish_clears_hash, s1_adv && s1_finish, running_hash == '0)
  `ZPH_ASSERT_NEXT(a_finish_fills_output, s1_adv && s1_finish, o_valid)

endmodule

`default_nettype wire

>>> dv/tb_zobrist_position_hash_top.sv
module tb_zobrist_position_hash_top;
  import zph_pkg::*;

  localparam int unsigned PIECE_ROWS  = PIECE_ROWS_DEF;
  localparam int unsigned SQUARES     = SQUARES_DEF;
  localparam int unsigned CASTLE_BASE = PIECE_ROWS * SQUARES;
  localparam int unsigned SIDE_INDEX  = CASTLE_BASE + CASTLE_KEYS;
  localparam int unsigned KEY_DEPTH   = SIDE_INDEX + 1;
  localparam int unsigned INDEX_MAX   = (1 << INDEX_W) - 1;
  localparam int unsigned SQUARE_MAX  = (1 << SQUARE_W) - 1;
  localparam int unsigned PIECE_MAX   = (1 << PIECE_W) - 1;

  localparam int SETTLE_CYCLES   = 4;
  localparam int STALL_LIMIT     = 1000;
  localparam int PHASE_ITEMS     = 70;
  localparam int LOADED_EACH_END = 4;

  localparam key_t KEY_ONES      = '1;
  localparam key_t CASTLE_15_KEY = 64'h8000_0000_0000_0001;
  localparam key_t SQ0_KEY       = 64'hA5A5_A5A5_A5A5_A5A5;

  typedef struct packed {
    action_t               action;
    logic [INDEX_W-1:0]    key_index;
    key_t                  key_value;
    logic [SQUARE_W-1:0]   square;
    logic [PIECE_W-1:0]    piece;
    logic                  side;
    logic                  ep_valid;
    logic [SQUARE_W-1:0]   ep_square;
    logic [CASTLE_W-1:0]   castle;
  } beat_t;

  typedef struct packed {
    beat_t beat;
    logic  typed;
    key_t  hash;
  } step_t;

  function automatic step_t put_key(input int unsigned idx, input key_t val);
    step_t s;
    s = '0;
    s.beat.action    = ACT_WRITE_KEY;
    s.beat.key_index = idx[INDEX_W-1:0];
    s.beat.key_value = val;
    return s;
  endfunction

  function automatic step_t put_piece(input int unsigned pc, input int unsigned sq);
    step_t s;
    s = '0;
    s.beat.action = ACT_ADD_PIECE;
    s.beat.piece  = pc[PIECE_W-1:0];
    s.beat.square = sq[SQUARE_W-1:0];
    return s;
  endfunction

  function automatic step_t close_pos(input logic sd, input logic epv,
                                      input int unsigned eps, input int unsigned cr);
    step_t s;
    s = '0;
    s.beat.action    = ACT_FINISH;
    s.beat.side      = sd;
    s.beat.ep_valid  = epv;
    s.beat.ep_square = eps[SQUARE_W-1:0];
    s.beat.castle    = cr[CASTLE_W-1:0];
    return s;
  endfunction

  function automatic step_t close_known(input logic sd, input logic epv, input int unsigned eps,
                                        input int unsigned cr, input key_t h);
    step_t s;
    s = close_pos(sd, epv, eps, cr);
    s.typed = 1'b1;
    s.hash  = h;
    return s;
  endfunction

  function automatic step_t no_action();
    step_t s;
    s = '0;
    s.beat.action    = ACT_NONE;
    s.beat.key_index = INDEX_MAX[INDEX_W-1:0];
    s.beat.key_value = KEY_ONES;
    s.beat.piece     = 4'd1;
    return s;
  endfunction

  // Squares whose keys get loaded: a few at each end of the board.
  function automatic int unsigned loaded_square(input int unsigned k);
    return (k < LOADED_EACH_END) ? k : SQUARES - 2 * LOADED_EACH_END + k;
  endfunction

  // Empty code is 0 while this script runs, and the running hash is clear.
  localparam int SCRIPT_LEN = 24;
  localparam step_t SCRIPT [SCRIPT_LEN] = '{
    put_key(SIDE_INDEX, KEY_ONES),
    put_key(CASTLE_BASE, '0),
    put_key(CASTLE_BASE + CASTLE_KEYS - 1, CASTLE_15_KEY),
    close_known(1'b0, 1'b0, 0, 0, '0),
    close_known(1'b1, 1'b0, 0, 0, KEY_ONES),
    close_known(1'b1, 1'b0, 0, CASTLE_KEYS - 1, ~CASTLE_15_KEY),
    put_key(KEY_DEPTH, 64'h5555_5555_5555_5555),
    put_key(INDEX_MAX, KEY_ONES),
    no_action(),
    close_known(1'b0, 1'b1, SQUARES, 0, '0),
    put_key(0, SQ0_KEY),
    put_piece(0, 0),
    put_piece(PIECE_ROWS, 0),
    put_piece(15, 127),
    put_piece(5, SQUARES),
    close_known(1'b0, 1'b1, 0, 0, SQ0_KEY),
    put_key((PIECE_ROWS - 1) * SQUARES + SQUARES - 1, 64'h0123_4567_89AB_CDEF),
    put_piece(PIECE_ROWS - 1, SQUARES - 1),
    put_piece(PIECE_ROWS - 1, SQUARES - 1),
    put_piece(PIECE_ROWS - 1, SQUARES - 1),
    close_pos(1'b1, 1'b1, 127, CASTLE_KEYS - 1),
    put_piece(1, 0),
    close_pos(1'b0, 1'b0, 0, 3),
    close_pos(1'b0, 1'b1, SQUARES - 1, 0)
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [PIECE_W-1:0] cfg_wdata;

  zph_item_if item_in ();
  zph_hash_if hash_out ();

  zobrist_position_hash_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .item_in  (item_in),
    .hash_out (hash_out)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the engine state.
  key_t               key_store [KEY_DEPTH];
  key_t               running_hash = '0;
  logic [PIECE_W-1:0] empty_code = '0;
  key_t               pending_hashes [$];

  bit          calm = 1'b0;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned hashes_checked = 0;
  int unsigned codes_tried = 0;
  int          stall_cycles = 0;
  key_t        want;

  function automatic bit hash_step(input beat_t b, output key_t h);
    logic [INDEX_W-1:0] idx;
    h = '0;
    case (b.action)
      ACT_WRITE_KEY: begin
        if (b.key_index < KEY_DEPTH) key_store[b.key_index] = b.key_value;
      end
      ACT_ADD_PIECE: begin
        if (b.piece != empty_code && b.piece < PIECE_ROWS && b.square < SQUARES) begin
          idx = INDEX_W'(b.piece * SQUARES + b.square);
          running_hash ^= key_store[idx];
        end
      end
      ACT_FINISH: begin
        h = running_hash;
        if (b.side) h ^= key_store[SIDE_INDEX];
        if (b.ep_valid && b.ep_square < SQUARES && empty_code < PIECE_ROWS) begin
          idx = INDEX_W'(empty_code * SQUARES + b.ep_square);
          h ^= key_store[idx];
        end
        idx = INDEX_W'(CASTLE_BASE + b.castle);
        h ^= key_store[idx];
        running_hash = '0;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic beat_t noise_beat();
    beat_t b;
    b.action    = ACT_NONE;
    b.key_index = INDEX_W'($urandom_range(INDEX_MAX));
    b.key_value = {$urandom, $urandom};
    b.square    = SQUARE_W'($urandom_range(SQUARE_MAX));
    b.piece     = PIECE_W'($urandom_range(PIECE_MAX));
    b.side      = 1'($urandom_range(1));
    b.ep_valid  = 1'($urandom_range(1));
    b.ep_square = SQUARE_W'($urandom_range(SQUARE_MAX));
    b.castle    = CASTLE_W'($urandom_range(CASTLE_KEYS - 1));
    return b;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("ERROR at %0t: %s", $time, what);
  endtask

  // Drives one beat, waits for it to be taken, then updates the shadow state.
  task automatic send(input beat_t b, input logic typed, input key_t typed_hash);
    key_t h;
    while (!calm && $urandom_range(99) < 21) begin
      item_in.valid <= 1'b0;
      @(posedge clk);
    end
    item_in.valid            <= 1'b1;
    item_in.action           <= b.action;
    item_in.key_index        <= b.key_index;
    item_in.key_value        <= b.key_value;
    item_in.square           <= b.square;
    item_in.piece            <= b.piece;
    item_in.side_to_move     <= b.side;
    item_in.enpassant_valid  <= b.ep_valid;
    item_in.enpassant_square <= b.ep_square;
    item_in.castle_rights    <= b.castle;
    @(posedge clk);
    while (!item_in.ready) @(posedge clk);
    if (hash_step(b, h)) pending_hashes.push_back(typed ? typed_hash : h);
    if (b.action != ACT_NONE) items_sent++;
  endtask

  task automatic drain();
    item_in.valid <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_empty_code(input logic [PIECE_W-1:0] code);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= code;
    @(posedge clk);
    cfg_we     <= 1'b0;
    empty_code = code;
    codes_tried++;
  endtask

  // Mostly whole positions: a run of pieces closed by a finish beat.
  // Every key that a beat can read here has been loaded.
  task automatic random_phase(input int unsigned budget);
    int unsigned stop_at;
    int unsigned n;
    beat_t b;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      case ($urandom_range(9))
        0: begin
          b = noise_beat();
          b.action = ACT_WRITE_KEY;
          send(b, 1'b0, '0);
        end
        1: begin
          send(noise_beat(), 1'b0, '0);
        end
        default: begin
          n = $urandom_range(16);
          repeat (n) begin
            b = noise_beat();
            b.action = ACT_ADD_PIECE;
            if ($urandom_range(9) != 0) begin
              b.square = SQUARE_W'(loaded_square($urandom_range(2 * LOADED_EACH_END - 1)));
              b.piece  = PIECE_W'($urandom_range(PIECE_ROWS - 1));
            end else begin
              // A piece that must be skipped.
              case ($urandom_range(2))
                0: b.square = SQUARE_W'(SQUARES + $urandom_range(SQUARE_MAX - SQUARES));
                1: b.piece  = empty_code;
                default: b.piece = PIECE_W'(PIECE_ROWS + $urandom_range(PIECE_MAX - PIECE_ROWS));
              endcase
            end
            send(b, 1'b0, '0);
          end
          b = noise_beat();
          b.action = ACT_FINISH;
          if ($urandom_range(4) != 0) begin
            b.ep_square = SQUARE_W'(loaded_square($urandom_range(2 * LOADED_EACH_END - 1)));
          end else begin
            b.ep_square = SQUARE_W'(SQUARES + $urandom_range(SQUARE_MAX - SQUARES));
          end
          send(b, 1'b0, '0);
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (!rst && hash_out.valid && hash_out.ready) begin
      hashes_checked++;
      if (pending_hashes.size() == 0) begin
        report_mismatch($sformatf("hash %h arrived with none outstanding", hash_out.hash));
      end else begin
        want = pending_hashes.pop_front();
        if (hash_out.hash !== want)
          report_mismatch($sformatf("hash %h, expected %h", hash_out.hash, want));
      end
    end
    hash_out.ready <= calm || ($urandom_range(99) >= 21);
  end

  always @(posedge clk) begin
    if (rst || (item_in.valid && item_in.ready) || (hash_out.valid && hash_out.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
      $display("zobrist_position_hash_top: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [PIECE_W-1:0] phase_codes [5];
    beat_t b;
    rst                      <= 1'b1;
    cfg_we                   <= 1'b0;
    cfg_wdata                <= '0;
    item_in.valid            <= 1'b0;
    item_in.action           <= ACT_NONE;
    item_in.key_index        <= '0;
    item_in.key_value        <= '0;
    item_in.square           <= '0;
    item_in.piece            <= '0;
    item_in.side_to_move     <= 1'b0;
    item_in.enpassant_valid  <= 1'b0;
    item_in.enpassant_square <= '0;
    item_in.castle_rights    <= '0;
    phase_codes = '{4'd12, 4'd0, 4'd6, 4'd11, 4'd0};
    phase_codes[4] = PIECE_W'($urandom_range(PIECE_ROWS - 1));
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    set_empty_code(4'd0);
    // Keys are loaded for every row at the squares near both ends of the board,
    // then all castle keys and the side key.
    for (int r = 0; r < PIECE_ROWS; r++) begin
      for (int k = 0; k < 2 * LOADED_EACH_END; k++) begin
        b = noise_beat();
        b.action    = ACT_WRITE_KEY;
        b.key_index = INDEX_W'(r * SQUARES + loaded_square(k));
        send(b, 1'b0, '0);
      end
    end
    for (int i = CASTLE_BASE; i < KEY_DEPTH; i++) begin
      b = noise_beat();
      b.action    = ACT_WRITE_KEY;
      b.key_index = i[INDEX_W-1:0];
      send(b, 1'b0, '0);
    end
    for (int i = 0; i < SCRIPT_LEN; i++)
      send(SCRIPT[i].beat, SCRIPT[i].typed, SCRIPT[i].hash);

    for (int p = 0; p < 5; p++) begin
      set_empty_code(phase_codes[p]);
      calm = (p == 1);
      random_phase(PHASE_ITEMS);
    end
    calm = 1'b0;
    drain();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d beats, %0d position hashes checked, %0d empty-code settings.",
             items_sent, hashes_checked, codes_tried);
    if (mismatches == 0) begin
      $display("zobrist_position_hash_top: match");
    end else begin
      $display("%0d errors found", mismatches);
      $display("zobrist_position_hash_top: mismatch");
    end
    $finish;
  end

endmodule
